[hdl/apc_pkg.sv]
package apc_pkg;

    // Field widths
    localparam int unsigned EV_W     = 3;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned USED_W   = 16;
    localparam int unsigned STEP_W   = 8;
    localparam int unsigned FRAMES_W = 32;
    localparam int unsigned RATE_W   = 20;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned STATE_W  = 3;
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned CFG_DW   = 32;

    // Divider widths: dividend holds frames times 1000, divisor holds a 32-bit length
    localparam int unsigned DVD_W    = 42;
    localparam int unsigned DSR_W    = 32;

    // Stream word widths
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned S_USER_W = EV_W;
    localparam int unsigned M_DATA_W = 120;

    // Event codes
    localparam logic [EV_W-1:0] EV_TICK    = 3'd0;
    localparam logic [EV_W-1:0] EV_OPEN    = 3'd1;
    localparam logic [EV_W-1:0] EV_TOGGLE  = 3'd2;
    localparam logic [EV_W-1:0] EV_STOP    = 3'd3;
    localparam logic [EV_W-1:0] EV_FRAMES  = 3'd4;
    localparam logic [EV_W-1:0] EV_UNDERUN = 3'd5;
    localparam logic [EV_W-1:0] EV_EXHAUST = 3'd6;
    localparam logic [EV_W-1:0] EV_VOLUME  = 3'd7;

    // Playback modes
    localparam logic [STATE_W-1:0] ST_STOPPED   = 3'd0;
    localparam logic [STATE_W-1:0] ST_BUFFERING = 3'd1;
    localparam logic [STATE_W-1:0] ST_PLAYING   = 3'd2;
    localparam logic [STATE_W-1:0] ST_PAUSED    = 3'd3;
    localparam logic [STATE_W-1:0] ST_EOF       = 3'd4;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_PREROLL = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_REFILL  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_LENGTH  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_RATE    = 2'd3;

    // Reset values and limits
    localparam logic [PCT_W-1:0] PREROLL_RST = 7'd75;
    localparam logic [PCT_W-1:0] REFILL_RST  = 7'd50;
    localparam logic [PCT_W-1:0] VOLUME_RST  = 7'd60;
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [9:0]       MS_PER_S    = 10'd1000;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul;
        logic div_start;
        logic load_out;
    } apc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } apc_stat_t;

endpackage

[hdl/apc_div.sv]
module apc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [apc_pkg::DVD_W-1:0]   dividend,
    input  logic [apc_pkg::DSR_W-1:0]   divisor,
    output logic                        busy,
    output logic [apc_pkg::DVD_W-1:0]   quotient
);

    localparam int unsigned STEP_CW = $clog2(apc_pkg::DVD_W);
    localparam logic [STEP_CW-1:0] LAST_STEP = STEP_CW'(apc_pkg::DVD_W - 1);

    logic [apc_pkg::DVD_W-1:0] quo_reg;
    logic [apc_pkg::DSR_W-1:0] rem_reg;
    logic [apc_pkg::DSR_W-1:0] dsr_reg;
    logic [STEP_CW-1:0]        cnt_reg;
    logic                      busy_reg;

    logic [apc_pkg::DSR_W:0]   rem_sh;
    logic                      ge;
    logic [apc_pkg::DSR_W:0]   rem_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[apc_pkg::DVD_W-1]};
        ge       = rem_sh >= {1'b0, dsr_reg};
        rem_diff = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[apc_pkg::DVD_W-2:0], ge};
            rem_reg <= ge ? rem_diff[apc_pkg::DSR_W-1:0] : rem_sh[apc_pkg::DSR_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hdl/apc_ctrl.sv]
module apc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  apc_pkg::apc_stat_t stat,
    output apc_pkg::apc_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequence one event: capture, apply, scale, divide, publish
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                // hold until both quotients are in and the output slot is free
                if (!stat.div_busy && stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/apc_dpath.sv]
module apc_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  apc_pkg::apc_cmd_t              cmd,
    output apc_pkg::apc_stat_t             stat,
    input  logic [apc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [apc_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                           cfg_wr_en,
    input  logic [apc_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [apc_pkg::CFG_DW-1:0]     cfg_wr_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [apc_pkg::M_DATA_W-1:0]   m_tdata
);

    // Configuration
    logic [apc_pkg::PCT_W-1:0]    preroll_reg;
    logic [apc_pkg::PCT_W-1:0]    refill_reg;
    logic [apc_pkg::FRAMES_W-1:0] length_reg;
    logic [apc_pkg::RATE_W-1:0]   rate_reg;

    // Captured event
    logic [apc_pkg::EV_W-1:0]     ev_reg;
    logic [apc_pkg::PCT_W-1:0]    level_reg;
    logic [apc_pkg::USED_W-1:0]   used_reg;
    logic                         exh_in_reg;
    logic signed [apc_pkg::STEP_W-1:0] step_reg;

    // Player state
    logic [apc_pkg::STATE_W-1:0]  mode_reg,   mode_next;
    logic [apc_pkg::FRAMES_W-1:0] frames_reg, frames_next;
    logic [apc_pkg::PCT_W-1:0]    vol_reg,    vol_next;
    logic [apc_pkg::CNT_W-1:0]    under_reg,  under_next;
    logic                         exh_reg,    exh_next;

    // Scaled dividends
    logic [apc_pkg::DVD_W-1:0]    pos_dvd_reg;
    logic [apc_pkg::DVD_W-1:0]    prog_dvd_reg;

    logic [apc_pkg::FRAMES_W:0]   sum;
    logic [apc_pkg::FRAMES_W-1:0] sum_sat;
    logic signed [9:0]            vol_sum;

    logic                         pos_busy, prog_busy;
    logic [apc_pkg::DVD_W-1:0]    pos_q, prog_q;

    logic [apc_pkg::FRAMES_W-1:0] pos_ms;
    logic [apc_pkg::PCT_W-1:0]    prog_pct;
    logic                         refill;
    logic [apc_pkg::M_DATA_W-1:0] out_word;

    logic                         m_tvalid_reg;
    logic [apc_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preroll_reg <= apc_pkg::PREROLL_RST;
            refill_reg  <= apc_pkg::REFILL_RST;
            length_reg  <= '0;
            rate_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                apc_pkg::CFG_PREROLL: preroll_reg <= cfg_wr_data[apc_pkg::PCT_W-1:0];
                apc_pkg::CFG_REFILL:  refill_reg  <= cfg_wr_data[apc_pkg::PCT_W-1:0];
                apc_pkg::CFG_LENGTH:  length_reg  <= cfg_wr_data[apc_pkg::FRAMES_W-1:0];
                apc_pkg::CFG_RATE:    rate_reg    <= cfg_wr_data[apc_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted event
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ev_reg     <= s_tuser;
            level_reg  <= s_tdata[6:0];
            used_reg   <= s_tdata[22:7];
            exh_in_reg <= s_tdata[23];
            step_reg   <= s_tdata[31:24];
        end
    end

    // Saturating frame add, clamped to a known track length
    always_comb begin
        sum     = {1'b0, frames_reg} + {{(apc_pkg::FRAMES_W+1-apc_pkg::USED_W){1'b0}}, used_reg};
        sum_sat = sum[apc_pkg::FRAMES_W] ? '1 : sum[apc_pkg::FRAMES_W-1:0];
        if (length_reg != '0 && sum_sat > length_reg) begin
            sum_sat = length_reg;
        end
        vol_sum = $signed({3'b000, vol_reg}) + 10'(step_reg);
    end

    // Apply the event to the player state
    always_comb begin
        mode_next   = mode_reg;
        frames_next = frames_reg;
        vol_next    = vol_reg;
        under_next  = under_reg;
        exh_next    = exh_reg;
        unique case (ev_reg)
            apc_pkg::EV_TICK: begin
                if (mode_reg == apc_pkg::ST_BUFFERING) begin
                    if (level_reg >= preroll_reg || exh_reg) begin
                        mode_next = apc_pkg::ST_PLAYING;
                    end
                end else if (mode_reg == apc_pkg::ST_PLAYING) begin
                    if (exh_reg && level_reg == '0) begin
                        mode_next = apc_pkg::ST_EOF;
                    end
                end
            end
            apc_pkg::EV_OPEN: begin
                frames_next = '0;
                exh_next    = 1'b0;
                mode_next   = apc_pkg::ST_BUFFERING;
            end
            apc_pkg::EV_TOGGLE: begin
                if (mode_reg == apc_pkg::ST_PLAYING) begin
                    mode_next = apc_pkg::ST_PAUSED;
                end else if (mode_reg == apc_pkg::ST_PAUSED) begin
                    mode_next = apc_pkg::ST_PLAYING;
                end
            end
            apc_pkg::EV_STOP: begin
                mode_next   = apc_pkg::ST_STOPPED;
                frames_next = '0;
            end
            apc_pkg::EV_FRAMES: begin
                if (mode_reg == apc_pkg::ST_PLAYING) begin
                    frames_next = sum_sat;
                end
            end
            apc_pkg::EV_UNDERUN: begin
                if (mode_reg == apc_pkg::ST_PLAYING) begin
                    under_next = under_reg + 1'b1;
                end
            end
            apc_pkg::EV_EXHAUST: begin
                exh_next = exh_in_reg;
            end
            apc_pkg::EV_VOLUME: begin
                if (vol_sum < 0) begin
                    vol_next = '0;
                end else if (vol_sum > 10'sd100) begin
                    vol_next = apc_pkg::PCT_MAX;
                end else begin
                    vol_next = vol_sum[apc_pkg::PCT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= apc_pkg::ST_STOPPED;
            frames_reg <= '0;
            vol_reg    <= apc_pkg::VOLUME_RST;
            under_reg  <= '0;
            exh_reg    <= 1'b0;
        end else if (cmd.exec) begin
            mode_reg   <= mode_next;
            frames_reg <= frames_next;
            vol_reg    <= vol_next;
            under_reg  <= under_next;
            exh_reg    <= exh_next;
        end
    end

    // Scale the frame count for milliseconds and percent
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            pos_dvd_reg  <= apc_pkg::DVD_W'(frames_reg) * apc_pkg::DVD_W'(apc_pkg::MS_PER_S);
            prog_dvd_reg <= apc_pkg::DVD_W'(frames_reg) * apc_pkg::DVD_W'(apc_pkg::PCT_MAX);
        end
    end

    apc_div u_pos_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (pos_dvd_reg),
        .divisor  (apc_pkg::DSR_W'(rate_reg)),
        .busy     (pos_busy),
        .quotient (pos_q)
    );

    apc_div u_prog_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prog_dvd_reg),
        .divisor  (length_reg),
        .busy     (prog_busy),
        .quotient (prog_q)
    );

    // Form the result word
    always_comb begin
        pos_ms = (rate_reg == '0) ? '0 : pos_q[apc_pkg::FRAMES_W-1:0];
        if (length_reg == '0) begin
            prog_pct = '0;
        end else if (prog_q > apc_pkg::DVD_W'(apc_pkg::PCT_MAX)) begin
            prog_pct = apc_pkg::PCT_MAX;
        end else begin
            prog_pct = prog_q[apc_pkg::PCT_W-1:0];
        end

        if (exh_reg || mode_reg == apc_pkg::ST_STOPPED || mode_reg == apc_pkg::ST_EOF) begin
            refill = 1'b0;
        end else if (mode_reg == apc_pkg::ST_BUFFERING) begin
            refill = level_reg < preroll_reg;
        end else begin
            refill = level_reg < refill_reg;
        end

        out_word = {5'b00000, under_reg, prog_pct, pos_ms, frames_reg, vol_reg, refill,
                    (mode_reg == apc_pkg::ST_PLAYING), mode_reg};
    end

    // Output register; the next event can be taken while this one waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= out_word;
        end
    end

    assign stat.div_busy = pos_busy | prog_busy;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

[hdl/audio_playback_controller.sv]
// Audio playback sequencer.
// Input stream (s_*): one event per transfer. s_tuser carries the event kind
// (tick, open, play/pause, stop, frames consumed, underrun, set exhausted,
// volume step); s_tdata carries buffer level, frames used, exhausted flag and
// signed volume step.
// Result stream (m_*): one transfer per event with mode, output enable,
// refill request, volume, played frames, position in ms, percent progress
// and underrun count, all taken after the event is applied.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_addr
// (0 preroll %, 1 refill %, 2 track length, 3 frame rate); write only idle.
// Sequence: an accepted event is applied, scaled and loaded into the dividers,
// the divide steps follow, then the result is published and the controller
// returns to idle, the only state that takes a new event. Two 42-step
// restoring dividers run side by side (position and progress).
// Reset: mode stopped, frames and underruns zero, volume 60, thresholds 75/50.
// A stalled result waits in the output register; the next event is still
// accepted and processed, and its result is published once the slot frees.
module audio_playback_controller (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [6:0] buffer_level_pct, [22:7] frames_used, [23] exhausted_in, [31:24] volume_step
    input  logic [apc_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] event kind
    input  logic [apc_pkg::S_USER_W-1:0] s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] play_state, [3] output_enable, [4] refill_request, [11:5] volume_level,
    // [43:12] played_frames, [75:44] position_ms, [82:76] progress_pct,
    // [114:83] underrun_total, [119:115] zero
    output logic [apc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [apc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [apc_pkg::CFG_DW-1:0]   cfg_wr_data
);

    apc_pkg::apc_cmd_t  cmd;
    apc_pkg::apc_stat_t stat;

    apc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    apc_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // One event in flight: no new transfer right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("event accepted while another is in progress");

    // Output enable tracks the playing mode
    a_enable_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == apc_pkg::ST_PLAYING)))
        else $error("output enable disagrees with mode");

    // Volume and progress stay within 0..100
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:5] <= apc_pkg::PCT_MAX && m_tdata[82:76] <= apc_pkg::PCT_MAX))
        else $error("percent field out of range");

    // A result is only published when the previous one has been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwritten before transfer");

endmodule

[sim/tb_audio_playback_controller.sv]
module tb_audio_playback_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 800;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_PRINTS   = 50;

    // One event as offered on the input stream
    typedef struct packed {
        logic [apc_pkg::EV_W-1:0]   kind;
        logic [apc_pkg::PCT_W-1:0]  level;
        logic [apc_pkg::USED_W-1:0] used;
        logic                       exh;
        logic [apc_pkg::STEP_W-1:0] step;
    } playback_evt_t;

    // Player status reported after each event
    typedef struct packed {
        logic [apc_pkg::STATE_W-1:0]  state;
        logic                         oe;
        logic                         refill;
        logic [apc_pkg::PCT_W-1:0]    vol;
        logic [apc_pkg::FRAMES_W-1:0] played;
        logic [31:0]                  pos;
        logic [apc_pkg::PCT_W-1:0]    prog;
        logic [apc_pkg::CNT_W-1:0]    underruns;
    } status_t;

    logic                           aclk;
    logic                           aresetn     = 1'b0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [apc_pkg::S_DATA_W-1:0]   s_tdata     = '0;
    logic [apc_pkg::S_USER_W-1:0]   s_tuser     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [apc_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_wr_en   = 1'b0;
    logic [apc_pkg::CFG_AW-1:0]     cfg_addr    = '0;
    logic [apc_pkg::CFG_DW-1:0]     cfg_wr_data = '0;

    // Predictor copy of the player state and registers
    logic [apc_pkg::STATE_W-1:0]  pb_mode      = apc_pkg::ST_STOPPED;
    logic [apc_pkg::FRAMES_W-1:0] pb_frames    = '0;
    logic [apc_pkg::PCT_W-1:0]    pb_volume    = apc_pkg::VOLUME_RST;
    logic [apc_pkg::CNT_W-1:0]    pb_underruns = '0;
    logic                         pb_exhausted = 1'b0;
    logic [apc_pkg::PCT_W-1:0]    thr_preroll  = apc_pkg::PREROLL_RST;
    logic [apc_pkg::PCT_W-1:0]    thr_refill   = apc_pkg::REFILL_RST;
    logic [apc_pkg::FRAMES_W-1:0] trk_length   = '0;
    logic [apc_pkg::RATE_W-1:0]   trk_rate     = '0;

    playback_evt_t pending_evt_q[$];
    status_t       expected_status_q[$];
    playback_evt_t offered_evt;

    int  tx_idle_pct = 34;
    int  rx_idle_pct = 34;
    logic rx_hold    = 1'b0;
    int  cycle_cnt   = 0;
    int  n_accepted  = 0;
    int  n_checked   = 0;
    int  n_errors    = 0;
    int  n_settings  = 0;
    int  eof_cnt     = 0;
    int  clamp_cnt   = 0;
    int  kind_cnt[8];

    audio_playback_controller dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Apply one event to the predicted player and return the status it reports
    function automatic status_t advance_playback(input playback_evt_t e);
        status_t     s;
        logic [32:0] sum;
        logic [63:0] scaled;
        int          vol;
        kind_cnt[e.kind]++;
        case (e.kind)
            apc_pkg::EV_TICK: begin
                if (pb_mode == apc_pkg::ST_BUFFERING) begin
                    if (e.level >= thr_preroll || pb_exhausted) pb_mode = apc_pkg::ST_PLAYING;
                end else if (pb_mode == apc_pkg::ST_PLAYING && pb_exhausted &&
                             e.level == '0) begin
                    pb_mode = apc_pkg::ST_EOF;
                    eof_cnt++;
                end
            end
            apc_pkg::EV_OPEN: begin
                pb_frames    = '0;
                pb_exhausted = 1'b0;
                pb_mode      = apc_pkg::ST_BUFFERING;
            end
            apc_pkg::EV_TOGGLE: begin
                if (pb_mode == apc_pkg::ST_PLAYING) pb_mode = apc_pkg::ST_PAUSED;
                else if (pb_mode == apc_pkg::ST_PAUSED) pb_mode = apc_pkg::ST_PLAYING;
            end
            apc_pkg::EV_STOP: begin
                pb_mode   = apc_pkg::ST_STOPPED;
                pb_frames = '0;
            end
            apc_pkg::EV_FRAMES: begin
                // Saturate at all ones, then clamp to a known track length
                if (pb_mode == apc_pkg::ST_PLAYING) begin
                    sum = {1'b0, pb_frames} + {17'd0, e.used};
                    if (sum[32]) sum = {1'b0, 32'hFFFF_FFFF};
                    if (trk_length != '0 && sum[31:0] > trk_length) begin
                        sum = {1'b0, trk_length};
                        clamp_cnt++;
                    end
                    pb_frames = sum[31:0];
                end
            end
            apc_pkg::EV_UNDERUN: begin
                if (pb_mode == apc_pkg::ST_PLAYING) pb_underruns = pb_underruns + 1'b1;
            end
            apc_pkg::EV_EXHAUST: begin
                pb_exhausted = e.exh;
            end
            default: begin
                vol = int'(pb_volume) + int'($signed(e.step));
                if (vol < 0) vol = 0;
                if (vol > int'(apc_pkg::PCT_MAX)) vol = int'(apc_pkg::PCT_MAX);
                pb_volume = vol[apc_pkg::PCT_W-1:0];
            end
        endcase

        s.state = pb_mode;
        s.oe    = (pb_mode == apc_pkg::ST_PLAYING);
        if (pb_exhausted || pb_mode == apc_pkg::ST_STOPPED || pb_mode == apc_pkg::ST_EOF)
            s.refill = 1'b0;
        else if (pb_mode == apc_pkg::ST_BUFFERING) s.refill = (e.level < thr_preroll);
        else s.refill = (e.level < thr_refill);
        s.vol    = pb_volume;
        s.played = pb_frames;
        s.pos    = '0;
        if (trk_rate != '0) begin
            scaled = (64'(pb_frames) * 64'd1000) / 64'(trk_rate);
            s.pos  = scaled[31:0];
        end
        s.prog = '0;
        if (trk_length != '0) begin
            scaled = (64'(pb_frames) * 64'd100) / 64'(trk_length);
            s.prog = (scaled > 64'(apc_pkg::PCT_MAX)) ? apc_pkg::PCT_MAX
                                                      : scaled[apc_pkg::PCT_W-1:0];
        end
        s.underruns = pb_underruns;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("ERROR @%0t result #%0d %s: got 0x%0h, want 0x%0h",
                     $time, n_checked, what, got, want);
    endtask

    // Compare one result transfer against the oldest expected status
    task automatic check_status(input logic [apc_pkg::M_DATA_W-1:0] w);
        status_t want;
        if (expected_status_q.size() == 0) begin
            report_mismatch("result with nothing expected", w[63:0], '0);
            return;
        end
        want = expected_status_q.pop_front();
        n_checked++;
        if (w[2:0] !== want.state)
            report_mismatch("play_state", 64'(w[2:0]), 64'(want.state));
        if (w[3] !== want.oe)
            report_mismatch("output_enable", 64'(w[3]), 64'(want.oe));
        if (w[4] !== want.refill)
            report_mismatch("refill_request", 64'(w[4]), 64'(want.refill));
        if (w[11:5] !== want.vol)
            report_mismatch("volume_level", 64'(w[11:5]), 64'(want.vol));
        if (w[43:12] !== want.played)
            report_mismatch("played_frames", 64'(w[43:12]), 64'(want.played));
        if (w[75:44] !== want.pos)
            report_mismatch("position_ms", 64'(w[75:44]), 64'(want.pos));
        if (w[82:76] !== want.prog)
            report_mismatch("progress_pct", 64'(w[82:76]), 64'(want.prog));
        if (w[114:83] !== want.underruns)
            report_mismatch("underrun_total", 64'(w[114:83]), 64'(want.underruns));
        if (w[119:115] !== '0)
            report_mismatch("pad bits", 64'(w[119:115]), '0);
    endtask

    // Driver: offer queued events, predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status_q.push_back(advance_playback(offered_evt));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_evt_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    offered_evt = pending_evt_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offered_evt.step, offered_evt.exh, offered_evt.used,
                                 offered_evt.level};
                    s_tuser  <= offered_evt.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, stall at random or on hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_status(m_tdata);
            m_tready <= !rx_hold && ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // Hold off the receiver once, long enough for the block to back up
    initial begin
        while (n_accepted < HOLD_AT) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_cnt, expected_status_q.size());
        $display("** audio_playback_controller: FAILED **");
        $finish;
    end

    task automatic write_reg(input logic [apc_pkg::CFG_AW-1:0] idx,
                             input logic [apc_pkg::CFG_DW-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            apc_pkg::CFG_PREROLL: thr_preroll = val[apc_pkg::PCT_W-1:0];
            apc_pkg::CFG_REFILL:  thr_refill  = val[apc_pkg::PCT_W-1:0];
            apc_pkg::CFG_LENGTH:  trk_length  = val[apc_pkg::FRAMES_W-1:0];
            apc_pkg::CFG_RATE:    trk_rate    = val[apc_pkg::RATE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned pre_pct, input int unsigned fill_pct,
                                 input int unsigned len, input int unsigned rate);
        n_settings++;
        write_reg(apc_pkg::CFG_PREROLL, pre_pct);
        write_reg(apc_pkg::CFG_REFILL, fill_pct);
        write_reg(apc_pkg::CFG_LENGTH, len);
        write_reg(apc_pkg::CFG_RATE, rate);
    endtask

    // Wait until every event is taken and every result is back, then let the block go quiet
    task automatic settle();
        @(negedge aclk);
        while (pending_evt_q.size() != 0 || s_tvalid || expected_status_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Queue one event; fields the kind does not use still carry random values
    task automatic add_evt(input logic [apc_pkg::EV_W-1:0] kind, input int level,
                           input int arg);
        playback_evt_t e;
        e.kind  = kind;
        e.level = level[apc_pkg::PCT_W-1:0];
        e.used  = 16'($urandom);
        e.exh   = 1'($urandom);
        e.step  = 8'($urandom);
        case (kind)
            apc_pkg::EV_FRAMES:  e.used = arg[apc_pkg::USED_W-1:0];
            apc_pkg::EV_EXHAUST: e.exh  = arg[0];
            apc_pkg::EV_VOLUME:  e.step = arg[apc_pkg::STEP_W-1:0];
            default: ;
        endcase
        pending_evt_q.push_back(e);
    endtask

    function automatic int rand_level();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0) return 0;
        if (pick == 1) return 100;
        return $urandom_range(100, 0);
    endfunction

    function automatic int rand_arg(input logic [apc_pkg::EV_W-1:0] kind);
        int pick;
        pick = $urandom_range(9, 0);
        case (kind)
            apc_pkg::EV_FRAMES: begin
                if (pick < 2) return 65535;
                if (pick < 4) return $urandom_range(15, 0);
                return $urandom_range(65535, 0);
            end
            apc_pkg::EV_EXHAUST: return (pick < 3) ? 1 : 0;
            default:             return $urandom_range(255, 0);
        endcase
    endfunction

    // Playback sessions: open, then mostly ticks and frame adds with the odd
    // toggle, underrun, volume step, exhaust, and broken-off stop or reopen
    task automatic add_sessions(input int n);
        int left;
        int run;
        int pick;
        logic [apc_pkg::EV_W-1:0] kind;
        left = n;
        // stray events first, acting on whatever state the last phase left
        repeat (4) begin
            kind = 3'($urandom_range(7, 0));
            if (kind == apc_pkg::EV_OPEN || kind == apc_pkg::EV_STOP) kind = apc_pkg::EV_FRAMES;
            add_evt(kind, rand_level(), rand_arg(kind));
            left--;
        end
        while (left > 0) begin
            add_evt(apc_pkg::EV_OPEN, rand_level(), 0);
            left--;
            run = $urandom_range(60, 5);
            while (run > 0 && left > 0) begin
                pick = $urandom_range(99, 0);
                if (pick < 25)      kind = apc_pkg::EV_TICK;
                else if (pick < 55) kind = apc_pkg::EV_FRAMES;
                else if (pick < 63) kind = apc_pkg::EV_TOGGLE;
                else if (pick < 73) kind = apc_pkg::EV_UNDERUN;
                else if (pick < 85) kind = apc_pkg::EV_VOLUME;
                else if (pick < 93) kind = apc_pkg::EV_EXHAUST;
                else if (pick < 97) kind = apc_pkg::EV_STOP;
                else                kind = apc_pkg::EV_OPEN;
                add_evt(kind, rand_level(), rand_arg(kind));
                run--;
                left--;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset register values: idle events, then preroll at 75
        add_evt(apc_pkg::EV_TICK, 100, 0);
        add_evt(apc_pkg::EV_FRAMES, 50, 65535);
        add_evt(apc_pkg::EV_OPEN, 74, 0);
        add_evt(apc_pkg::EV_TICK, 74, 0);
        add_evt(apc_pkg::EV_TICK, 75, 0);
        add_evt(apc_pkg::EV_FRAMES, 49, 1234);
        settle();

        // Volume clamps, length clamp, pause, end of file, exhausted preroll
        apply_setting(75, 50, 1000, 48000);
        add_evt(apc_pkg::EV_VOLUME, 30, 127);
        add_evt(apc_pkg::EV_VOLUME, 30, -128);
        add_evt(apc_pkg::EV_VOLUME, 30, 60);
        add_evt(apc_pkg::EV_EXHAUST, 30, 1);
        add_evt(apc_pkg::EV_OPEN, 30, 0);
        add_evt(apc_pkg::EV_TICK, 100, 0);
        add_evt(apc_pkg::EV_FRAMES, 50, 600);
        add_evt(apc_pkg::EV_UNDERUN, 49, 0);
        add_evt(apc_pkg::EV_FRAMES, 0, 65535);
        add_evt(apc_pkg::EV_TOGGLE, 10, 0);
        add_evt(apc_pkg::EV_FRAMES, 10, 10);
        add_evt(apc_pkg::EV_UNDERUN, 10, 0);
        add_evt(apc_pkg::EV_TOGGLE, 10, 0);
        add_evt(apc_pkg::EV_EXHAUST, 10, 1);
        add_evt(apc_pkg::EV_TICK, 1, 0);
        add_evt(apc_pkg::EV_TICK, 0, 0);
        add_evt(apc_pkg::EV_TOGGLE, 0, 0);
        add_evt(apc_pkg::EV_OPEN, 0, 0);
        add_evt(apc_pkg::EV_EXHAUST, 0, 1);
        add_evt(apc_pkg::EV_TICK, 0, 0);
        add_evt(apc_pkg::EV_STOP, 0, 0);
        settle();

        // Unknown length, the receiver hold-off lands in this phase
        apply_setting(75, 50, 0, 48000);
        add_sessions(260);
        settle();

        // Zero thresholds, fastest rate
        apply_setting(0, 0, 5_000_000, 768000);
        add_sessions(260);
        settle();

        // Length lowered under the frames already played, slowest rate
        apply_setting(100, 100, 200, 1);
        add_sessions(260);
        settle();

        // Thresholds above 100, length and rate unknown
        apply_setting(127, 127, 0, 0);
        add_sessions(260);
        settle();

        // Long play at rate 1 so the position wraps past 32 bits
        apply_setting(10, 60, 32'hFFFF_FFFF, 1);
        add_evt(apc_pkg::EV_OPEN, 50, 0);
        add_evt(apc_pkg::EV_TICK, 100, 0);
        repeat (80) add_evt(apc_pkg::EV_FRAMES, rand_level(), 65535);
        add_sessions(160);
        settle();

        // No idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting($urandom_range(100, 0), $urandom_range(100, 0),
                      $urandom_range(100000, 1), $urandom_range(768000, 1));
        add_sessions(260);
        settle();
        tx_idle_pct = 34;
        rx_idle_pct = 34;

        apply_setting($urandom_range(100, 0), $urandom_range(100, 0),
                      $urandom_range(100000, 1), $urandom_range(768000, 1));
        add_sessions(260);
        settle();

        // Shortest track, full preroll, no refill
        apply_setting(100, 0, 1, 768000);
        add_sessions(240);
        settle();

        $display("covered %0d events: tick %0d, open %0d, toggle %0d, stop %0d, frames %0d, "
                 , n_accepted, kind_cnt[apc_pkg::EV_TICK], kind_cnt[apc_pkg::EV_OPEN],
                 kind_cnt[apc_pkg::EV_TOGGLE], kind_cnt[apc_pkg::EV_STOP],
                 kind_cnt[apc_pkg::EV_FRAMES],
                 "underrun %0d, exhaust %0d, volume %0d",
                 kind_cnt[apc_pkg::EV_UNDERUN], kind_cnt[apc_pkg::EV_EXHAUST],
                 kind_cnt[apc_pkg::EV_VOLUME]);
        $display("%0d results checked over %0d register settings; %0d ends of file, "
                 , n_checked, n_settings, eof_cnt,
                 "%0d length clamps, %0d mismatches", clamp_cnt, n_errors);
        if (n_errors == 0) begin
            $display("** audio_playback_controller: PASSED **");
        end else begin
            $display("** audio_playback_controller: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/apc_pkg.sv
hdl/apc_div.sv
hdl/apc_ctrl.sv
hdl/apc_dpath.sv
hdl/audio_playback_controller.sv
sim/tb_audio_playback_controller.sv
